@@ hw/rtl/gssfr_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the gas sensor serial frame receiver
// no dependencies; used by the channel interfaces and every rtl module

package gssfr_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int EDGE_TIME_W = 32;
   localparam int GAP_W = 16;
   localparam int BYTE_W = 8;
   localparam int VALUE_W = 16;
   localparam int TEMP_W = 20;
   localparam int HEAD_BYTES = 4;

   localparam logic [GAP_W-1:0] GAP_LIMIT_RESET = 16'd2000;
   localparam logic [BYTE_W-1:0] ID_TEMP = 8'h42;
   localparam logic [BYTE_W-1:0] ID_CO2 = 8'h50;
   localparam logic [BYTE_W-1:0] TERMINATOR = 8'h0D;
   localparam logic [TEMP_W-1:0] KELVIN_CENTI = 20'd27315;
   localparam logic [4:0] TEMP_SCALE = 5'd25;
   localparam logic [2:0] LAST_HEAD_COUNT = 3'd4;

   typedef enum logic [1:0] {
      STATUS_CO2 = 2'd0,
      STATUS_TEMP = 2'd1,
      STATUS_OTHER = 2'd2,
      STATUS_BAD = 2'd3
   } frame_status_type;

   typedef struct packed {
      logic done;
      logic [HEAD_BYTES-1:0][BYTE_W-1:0] head;
      logic [BYTE_W-1:0] tail;
   } frame_type;

   typedef struct packed {
      frame_status_type frame_status;
      logic [BYTE_W-1:0] frame_id;
      logic [VALUE_W-1:0] frame_value;
      logic [VALUE_W-1:0] co2_ppm;
      logic co2_known;
      logic signed [TEMP_W-1:0] temp_centi_c;
      logic temp_known;
   } result_type;

endpackage

@@ hw/rtl/gssfr_channels.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces: edge items in, frame results out, csr writes
// depends on gssfr_pkg for field widths and types

interface gssfr_req_if;
   logic valid;
   logic ready;
   logic [gssfr_pkg::EDGE_TIME_W-1:0] edge_time_us;
   logic data_bit;

   modport source (output valid, output edge_time_us, output data_bit, input ready);
   modport sink (input valid, input edge_time_us, input data_bit, output ready);
endinterface

interface gssfr_rsp_if;
   logic valid;
   logic ready;
   gssfr_pkg::frame_status_type frame_status;
   logic [gssfr_pkg::BYTE_W-1:0] frame_id;
   logic [gssfr_pkg::VALUE_W-1:0] frame_value;
   logic [gssfr_pkg::VALUE_W-1:0] co2_ppm;
   logic co2_known;
   logic signed [gssfr_pkg::TEMP_W-1:0] temp_centi_c;
   logic temp_known;

   modport source (output valid, output frame_status, output frame_id, output frame_value,
                   output co2_ppm, output co2_known, output temp_centi_c,
                   output temp_known, input ready);
   modport sink (input valid, input frame_status, input frame_id, input frame_value,
                 input co2_ppm, input co2_known, input temp_centi_c,
                 input temp_known, output ready);
endinterface

interface gssfr_csr_if;
   logic valid;
   logic ready;
   logic [gssfr_pkg::GAP_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/gssfr_deframer.sv @@
`timescale 1ns / 1ps
// gap check, msb-first bit shifter and byte collector for five-byte frames
// depends on gssfr_pkg; feeds gssfr_decoder

module gssfr_deframer #(
   parameter int TIME_BITS = gssfr_pkg::TIME_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic [gssfr_pkg::EDGE_TIME_W-1:0] edge_time_us,
   input  logic data_bit,
   input  logic [gssfr_pkg::GAP_W-1:0] gap_limit_us,
   output gssfr_pkg::frame_type frame
);

   localparam int NOW_BITS = (TIME_BITS < gssfr_pkg::EDGE_TIME_W) ? TIME_BITS
                                                                   : gssfr_pkg::EDGE_TIME_W;

   logic [NOW_BITS-1:0] last_time_ff;
   logic [gssfr_pkg::BYTE_W-1:0] shift_ff, shift_in;
   logic [2:0] bit_count_ff, bit_count_in;
   logic [2:0] byte_count_ff, byte_count_in;
   logic [gssfr_pkg::HEAD_BYTES-1:0][gssfr_pkg::BYTE_W-1:0] store_ff;

   logic [NOW_BITS-1:0] now;
   logic [TIME_BITS-1:0] gap;
   logic gap_clear;
   logic [gssfr_pkg::BYTE_W-1:0] shift_base, shift_next;
   logic [2:0] bit_base, byte_base;
   logic byte_end, head_write;

   always_comb begin
      now = edge_time_us[NOW_BITS-1:0];
      gap = TIME_BITS'(now) - TIME_BITS'(last_time_ff);
      gap_clear = gap > TIME_BITS'(gap_limit_us);
      shift_base = gap_clear ? '0 : shift_ff;
      bit_base = gap_clear ? '0 : bit_count_ff;
      byte_base = gap_clear ? '0 : byte_count_ff;
      shift_next = {shift_base[gssfr_pkg::BYTE_W-2:0], data_bit};
      bit_count_in = bit_base + 3'd1;
      byte_end = (bit_count_in == 3'd0);
      head_write = byte_end && !byte_base[2];
      shift_in = shift_next;
      byte_count_in = byte_base;
      if (byte_end) begin
         shift_in = '0;
         byte_count_in = head_write ? (byte_base + 3'd1) : 3'd0;
      end
      frame.done = byte_end && byte_base[2];
      frame.head = store_ff;
      frame.tail = shift_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         shift_ff <= '0;
         bit_count_ff <= '0;
         byte_count_ff <= '0;
      end else if (step) begin
         last_time_ff <= now;
         shift_ff <= shift_in;
         bit_count_ff <= bit_count_in;
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && head_write) begin
         store_ff[byte_base[1:0]] <= shift_next;
      end
   end

   a_byte_count_range: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= gssfr_pkg::LAST_HEAD_COUNT)
      else $error("byte count beyond frame length");

   a_done_after_head: assert property (@(posedge clock) disable iff (reset)
      step && frame.done |-> byte_count_ff == gssfr_pkg::LAST_HEAD_COUNT && !gap_clear)
      else $error("frame completed without four stored bytes");

endmodule

@@ hw/rtl/gssfr_decoder.sv @@
`timescale 1ns / 1ps
// frame check, id decode and stored co2 / temperature readings
// depends on gssfr_pkg; driven by gssfr_deframer

module gssfr_decoder (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  gssfr_pkg::frame_type frame,
   output gssfr_pkg::result_type result
);

   logic [gssfr_pkg::VALUE_W-1:0] co2_ff, co2_in;
   logic co2_valid_ff, co2_valid_in;
   logic [gssfr_pkg::TEMP_W-1:0] temp_ff, temp_in;
   logic temp_valid_ff, temp_valid_in;

   logic [gssfr_pkg::BYTE_W-1:0] b0, b1, b2, b3, sum;
   logic [gssfr_pkg::VALUE_W-1:0] raw;
   logic [20:0] scaled;
   logic frame_ok;
   gssfr_pkg::frame_status_type status;

   always_comb begin
      b0 = frame.head[0];
      b1 = frame.head[1];
      b2 = frame.head[2];
      b3 = frame.head[3];
      raw = {b1, b2};
      sum = b0 + b1 + b2;
      frame_ok = (frame.tail == gssfr_pkg::TERMINATOR) && (sum == b3);
      scaled = 21'(raw) * 21'(gssfr_pkg::TEMP_SCALE);
      co2_in = co2_ff;
      co2_valid_in = co2_valid_ff;
      temp_in = temp_ff;
      temp_valid_in = temp_valid_ff;
      priority if (!frame_ok) begin
         status = gssfr_pkg::STATUS_BAD;
      end else if (b0 == gssfr_pkg::ID_CO2) begin
         status = gssfr_pkg::STATUS_CO2;
         co2_in = raw;
         co2_valid_in = 1'b1;
      end else if (b0 == gssfr_pkg::ID_TEMP) begin
         status = gssfr_pkg::STATUS_TEMP;
         temp_in = gssfr_pkg::TEMP_W'(scaled[20:2]) - gssfr_pkg::KELVIN_CENTI;
         temp_valid_in = 1'b1;
      end else begin
         status = gssfr_pkg::STATUS_OTHER;
      end
      result.frame_status = status;
      result.frame_id = b0;
      result.frame_value = raw;
      result.co2_ppm = co2_in;
      result.co2_known = co2_valid_in;
      result.temp_centi_c = temp_in;
      result.temp_known = temp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         co2_ff <= '0;
         co2_valid_ff <= 1'b0;
         temp_ff <= '0;
         temp_valid_ff <= 1'b0;
      end else if (step && frame.done) begin
         co2_ff <= co2_in;
         co2_valid_ff <= co2_valid_in;
         temp_ff <= temp_in;
         temp_valid_ff <= temp_valid_in;
      end
   end

   a_co2_known_sticky: assert property (@(posedge clock) disable iff (reset)
      co2_valid_ff |=> co2_valid_ff)
      else $error("co2 known flag dropped");

   a_temp_known_sticky: assert property (@(posedge clock) disable iff (reset)
      temp_valid_ff |=> temp_valid_ff)
      else $error("temperature known flag dropped");

   a_co2_stored: assert property (@(posedge clock) disable iff (reset)
      step && frame.done && status == gssfr_pkg::STATUS_CO2 |=> co2_ff == $past(raw))
      else $error("co2 frame not stored");

endmodule

@@ hw/rtl/gas_sensor_serial_frame_receiver.sv @@
`timescale 1ns / 1ps
// Receives one falling sensor clock edge per item (timestamp and data bit) and
// returns one result item per completed five-byte frame. Throughput is one edge item
// per clock cycle while no result waits unaccepted; an edge passes from the input
// register through gap check, byte collection and decode to the result register.
// A result item that waits unaccepted holds the input register, so the edge input
// stalls until the result channel takes it, whether or not the held edge completes
// a frame. The gap limit is written through the csr channel.
// depends on gssfr_pkg, gssfr_channels, gssfr_deframer and gssfr_decoder

module gas_sensor_serial_frame_receiver #(
   parameter int TIME_BITS = gssfr_pkg::TIME_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   gssfr_req_if.sink req_ch,
   gssfr_rsp_if.source rsp_ch,
   gssfr_csr_if.sink csr_ch
);

   logic [gssfr_pkg::GAP_W-1:0] gap_limit_ff;
   logic in_valid_ff;
   logic [gssfr_pkg::EDGE_TIME_W-1:0] edge_time_ff;
   logic data_bit_ff;
   logic rsp_valid_ff;
   gssfr_pkg::result_type rsp_data_ff;

   logic step;
   logic req_take;
   gssfr_pkg::frame_type frame;
   gssfr_pkg::result_type result;

   assign step = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;
   assign req_take = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff <= gssfr_pkg::GAP_LIMIT_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         gap_limit_ff <= csr_ch.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_take || (in_valid_ff && !step);
         if (step && frame.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         edge_time_ff <= req_ch.edge_time_us;
         data_bit_ff <= req_ch.data_bit;
      end
      if (step && frame.done) begin
         rsp_data_ff <= result;
      end
   end

   gssfr_deframer #(
      .TIME_BITS(TIME_BITS)
   ) u_deframer (
      .clock(clock),
      .reset(reset),
      .step(step),
      .edge_time_us(edge_time_ff),
      .data_bit(data_bit_ff),
      .gap_limit_us(gap_limit_ff),
      .frame(frame)
   );

   gssfr_decoder u_decoder (
      .clock(clock),
      .reset(reset),
      .step(step),
      .frame(frame),
      .result(result)
   );

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.frame_status = rsp_data_ff.frame_status;
   assign rsp_ch.frame_id = rsp_data_ff.frame_id;
   assign rsp_ch.frame_value = rsp_data_ff.frame_value;
   assign rsp_ch.co2_ppm = rsp_data_ff.co2_ppm;
   assign rsp_ch.co2_known = rsp_data_ff.co2_known;
   assign rsp_ch.temp_centi_c = rsp_data_ff.temp_centi_c;
   assign rsp_ch.temp_known = rsp_data_ff.temp_known;

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !step)
      else $error("pending result overwritten");

   a_co2_status_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_status == gssfr_pkg::STATUS_CO2 |-> rsp_data_ff.co2_known)
      else $error("co2 result without known flag");

endmodule
